// ===== sv/ipe_pkg.sv =====
// ----------------------------------------------------------------------------
// ipe_pkg: shared definitions for the add/sub/paren expression evaluator
// Word widths, character codes and the operator codes kept on the op stack.
// ----------------------------------------------------------------------------
package ipe_pkg;

  // Default depth of both stacks.
  localparam int unsigned STACK_DEPTH_DEF = 32;

  // Payload widths.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CHAR_W = 8;

  // Character codes that the evaluator reacts to.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_OPEN  = 8'h28;
  localparam logic [CHAR_W-1:0] CHAR_CLOSE = 8'h29;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Operator stack entries.
  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_PLUS  = 2'd1,
    OP_MINUS = 2'd2
  } op_code_e;

endpackage

// ===== sv/ipe_if.sv =====
// ----------------------------------------------------------------------------
// ipe_if: valid/ready channels of the expression evaluator
// One channel carries expression characters in, the other carries results out.
// ----------------------------------------------------------------------------
interface ipe_in_if;
  logic                            valid;
  logic                            ready;
  logic [ipe_pkg::CHAR_W-1:0]      char_code;
  logic                            is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface ipe_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [ipe_pkg::DATA_W-1:0] result_value;
  logic                            error_flag;

  modport source (output valid, output result_value, output error_flag, input ready);
  modport sink   (input valid, input result_value, input error_flag, output ready);
endinterface

// ===== sv/ipe_alu.sv =====
// ----------------------------------------------------------------------------
// ipe_alu: shared 32-bit adder/subtractor
// Serves the digit accumulation steps and every plus or minus reduction.
// ----------------------------------------------------------------------------
module ipe_alu (
  input  logic [ipe_pkg::DATA_W-1:0] a_i,
  input  logic [ipe_pkg::DATA_W-1:0] b_i,
  input  logic                       sub_i,
  output logic [ipe_pkg::DATA_W-1:0] sum_o
);

  logic [ipe_pkg::DATA_W-1:0] b_inv;

  // Subtraction is addition of the inverted operand plus one; result wraps.
  assign b_inv = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_inv + {{(ipe_pkg::DATA_W-1){1'b0}}, sub_i};

endmodule

// ===== sv/infix_add_sub_paren_evaluator.sv =====
// ----------------------------------------------------------------------------
// infix_add_sub_paren_evaluator: streaming evaluator for +, - and parentheses
// Takes one character per word, keeps value and operator stacks in memories
// with registered reads, and gives the value of the expression on the
// word that marks its end. All arithmetic goes through one shared adder.
// ----------------------------------------------------------------------------
// Words are taken one at a time: the input is ready only while the sequencer
// is idle, and the registered stack reads and the single adder set the steps.
// Reset clears the sequencer, counts and flags.
// ----------------------------------------------------------------------------
module infix_add_sub_paren_evaluator #(
  parameter int unsigned STACK_DEPTH = ipe_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ipe_in_if.sink     in_i,
  ipe_out_if.source  out_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW = ipe_pkg::DATA_W;
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_DIG_A    = 18'h00002,
    S_DIG_B    = 18'h00004,
    S_ACT      = 18'h00008,
    S_POST     = 18'h00010,
    S_FIN      = 18'h00020,
    S_FIN_OP   = 18'h00040,
    S_FIN_VAL  = 18'h00080,
    S_PUSH     = 18'h00100,
    S_CLOSE    = 18'h00200,
    S_CLOSE_OP = 18'h00400,
    S_LOOP     = 18'h00800,
    S_LOOP_OP  = 18'h01000,
    S_RED_R    = 18'h02000,
    S_RED_L    = 18'h04000,
    S_LAST_RD  = 18'h08000,
    S_LAST_V   = 18'h10000,
    S_EMIT     = 18'h20000
  } state_e;

  state_e                    state_q, state_d;
  logic [ipe_pkg::CHAR_W-1:0] char_q;
  logic                      last_q;
  logic [DW-1:0]             acc_q, acc_d;
  logic                      in_num_q, in_num_d;
  logic                      err_q, err_d;
  logic [CW-1:0]             vcnt_q, vcnt_d;
  logic [CW-1:0]             ocnt_q, ocnt_d;
  logic [DW-1:0]             opnd_q, opnd_d;
  logic [DW-1:0]             res_q, res_d;
  ipe_pkg::op_code_e         opsel_q, opsel_d;
  logic                      close_q, close_d;
  logic                      end_q, end_d;
  logic                      outv_q, outv_d;
  logic [DW-1:0]             out_val_q;
  logic                      out_err_q;

  logic [DW-1:0]             vmem [STACK_DEPTH];
  logic [1:0]                omem [STACK_DEPTH];
  logic [DW-1:0]             vrd_q;
  logic [1:0]                ord_q;

  logic                      v_we, o_we, out_load;
  logic [1:0]                o_wdata;
  logic [CW-1:0]             vaddr_full, oaddr_full;
  logic                      accept, out_free;
  logic                      in_digit, in_term;
  logic [DW-1:0]             lhs_pop;
  logic [DW-1:0]             alu_a, alu_b, alu_sum;
  logic                      alu_sub;

  // Handshake and classification of the incoming word.
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !outv_q || out_o.ready;
  assign in_digit   = (in_i.char_code >= ipe_pkg::CHAR_ZERO) &&
                      (in_i.char_code <= ipe_pkg::CHAR_NINE);
  assign in_term    = (in_i.char_code == ipe_pkg::CHAR_SPACE) ||
                      (in_i.char_code == ipe_pkg::CHAR_OPEN)  ||
                      (in_i.char_code == ipe_pkg::CHAR_CLOSE) ||
                      (in_i.char_code == ipe_pkg::CHAR_PLUS)  ||
                      (in_i.char_code == ipe_pkg::CHAR_MINUS);

  // Stack read addresses: the top entry, or the one under it while the right
  // operand of a reduction is being popped.
  assign vaddr_full = (state_q == S_RED_R) ? (vcnt_q - CW'(2)) : (vcnt_q - CW'(1));
  assign oaddr_full = ocnt_q - CW'(1);

  // A pop from an empty value stack reads as zero.
  assign lhs_pop = (vcnt_q != '0) ? vrd_q : '0;

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = lhs_pop;
    alu_b   = opnd_q;
    alu_sub = (opsel_q == ipe_pkg::OP_MINUS);
    case (state_q)
      S_DIG_A: begin
        alu_a   = acc_q << 3;
        alu_b   = acc_q << 1;
        alu_sub = 1'b0;
      end
      S_DIG_B: begin
        alu_a   = opnd_q;
        alu_b   = {{(DW-4){1'b0}}, char_q[3:0]};
        alu_sub = 1'b0;
      end
      S_FIN_VAL: begin
        alu_b = acc_q;
      end
      default: begin
        alu_b = opnd_q;
      end
    endcase
  end

  ipe_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  // Operator code for an opening paren, plus or minus.
  always_comb begin
    case (char_q)
      ipe_pkg::CHAR_PLUS:  o_wdata = ipe_pkg::OP_PLUS;
      ipe_pkg::CHAR_MINUS: o_wdata = ipe_pkg::OP_MINUS;
      default:             o_wdata = ipe_pkg::OP_OPEN;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    in_num_d = in_num_q;
    err_d    = err_q;
    vcnt_d   = vcnt_q;
    ocnt_d   = ocnt_q;
    opnd_d   = opnd_q;
    res_d    = res_q;
    opsel_d  = opsel_q;
    close_d  = close_q;
    end_d    = end_q;
    outv_d   = out_o.ready ? 1'b0 : outv_q;
    v_we     = 1'b0;
    o_we     = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_digit) begin
            state_d = S_DIG_A;
          end else if (in_term) begin
            end_d   = 1'b0;
            state_d = in_num_q ? S_FIN : S_ACT;
          end else begin
            state_d = S_POST;
          end
        end
      end
      S_DIG_A: begin
        opnd_d  = alu_sum;
        state_d = S_DIG_B;
      end
      S_DIG_B: begin
        acc_d    = alu_sum;
        in_num_d = 1'b1;
        state_d  = S_POST;
      end
      S_ACT: begin
        state_d = S_POST;
        case (char_q)
          ipe_pkg::CHAR_OPEN, ipe_pkg::CHAR_PLUS, ipe_pkg::CHAR_MINUS: begin
            if (ocnt_q == FULL) begin
              err_d = 1'b1;
            end else begin
              o_we   = 1'b1;
              ocnt_d = ocnt_q + CW'(1);
            end
          end
          ipe_pkg::CHAR_CLOSE: begin
            state_d = S_CLOSE;
          end
          default: begin
            state_d = S_POST;
          end
        endcase
      end
      S_POST: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (in_num_q) begin
          end_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          state_d = S_LAST_RD;
        end
      end
      S_FIN: begin
        if (ocnt_q == '0) begin
          res_d   = acc_q;
          state_d = S_PUSH;
        end else begin
          state_d = S_FIN_OP;
        end
      end
      S_FIN_OP: begin
        if (ord_q == ipe_pkg::OP_OPEN) begin
          res_d   = acc_q;
          state_d = S_PUSH;
        end else begin
          opsel_d = ipe_pkg::op_code_e'(ord_q);
          ocnt_d  = ocnt_q - CW'(1);
          state_d = S_FIN_VAL;
        end
      end
      S_FIN_VAL: begin
        if (vcnt_q == '0) begin
          err_d = 1'b1;
        end else begin
          vcnt_d = vcnt_q - CW'(1);
        end
        res_d   = alu_sum;
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (vcnt_q == FULL) begin
          err_d = 1'b1;
        end else begin
          v_we   = 1'b1;
          vcnt_d = vcnt_q + CW'(1);
        end
        acc_d    = '0;
        in_num_d = 1'b0;
        if (close_q) begin
          state_d = S_LOOP;
        end else begin
          state_d = end_q ? S_LAST_RD : S_ACT;
        end
      end
      S_CLOSE: begin
        state_d = S_CLOSE_OP;
      end
      S_CLOSE_OP: begin
        if ((ocnt_q != '0) && (ord_q == ipe_pkg::OP_OPEN)) begin
          ocnt_d = ocnt_q - CW'(1);
        end
        close_d = 1'b1;
        state_d = S_LOOP;
      end
      S_LOOP: begin
        if (ocnt_q == '0) begin
          close_d = 1'b0;
          state_d = S_POST;
        end else begin
          state_d = S_LOOP_OP;
        end
      end
      S_LOOP_OP: begin
        if (ord_q == ipe_pkg::OP_OPEN) begin
          close_d = 1'b0;
          state_d = S_POST;
        end else begin
          opsel_d = ipe_pkg::op_code_e'(ord_q);
          ocnt_d  = ocnt_q - CW'(1);
          state_d = S_RED_R;
        end
      end
      S_RED_R: begin
        opnd_d = lhs_pop;
        if (vcnt_q == '0) begin
          err_d = 1'b1;
        end else begin
          vcnt_d = vcnt_q - CW'(1);
        end
        state_d = S_RED_L;
      end
      S_RED_L: begin
        if (vcnt_q == '0) begin
          err_d = 1'b1;
        end else begin
          vcnt_d = vcnt_q - CW'(1);
        end
        res_d   = alu_sum;
        state_d = S_PUSH;
      end
      S_LAST_RD: begin
        state_d = S_LAST_V;
      end
      S_LAST_V: begin
        res_d = lhs_pop;
        if (vcnt_q == '0) begin
          err_d = 1'b1;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          outv_d   = 1'b1;
          vcnt_d   = '0;
          ocnt_d   = '0;
          acc_d    = '0;
          in_num_d = 1'b0;
          err_d    = 1'b0;
          close_d  = 1'b0;
          end_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      acc_q    <= '0;
      in_num_q <= 1'b0;
      err_q    <= 1'b0;
      vcnt_q   <= '0;
      ocnt_q   <= '0;
      close_q  <= 1'b0;
      end_q    <= 1'b0;
      outv_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_q    <= acc_d;
      in_num_q <= in_num_d;
      err_q    <= err_d;
      vcnt_q   <= vcnt_d;
      ocnt_q   <= ocnt_d;
      close_q  <= close_d;
      end_q    <= end_d;
      outv_q   <= outv_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= in_i.char_code;
      last_q <= in_i.is_last;
    end
    opnd_q  <= opnd_d;
    res_q   <= res_d;
    opsel_q <= opsel_d;
    if (out_load) begin
      out_val_q <= res_q;
      out_err_q <= err_q;
    end
  end

  // Value stack memory with registered read.
  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vmem[vcnt_q[AW-1:0]] <= res_q;
    end
    vrd_q <= vmem[vaddr_full[AW-1:0]];
  end

  // Operator stack memory with registered read.
  always_ff @(posedge clk_i) begin
    if (o_we) begin
      omem[ocnt_q[AW-1:0]] <= o_wdata;
    end
    ord_q <= omem[oaddr_full[AW-1:0]];
  end

  assign out_o.valid        = outv_q;
  assign out_o.result_value = out_val_q;
  assign out_o.error_flag   = out_err_q;

  // The fill counts never pass the stack depth.
  a_vcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= FULL)
    else $error("value stack count beyond depth");

  a_ocnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= FULL)
    else $error("operator stack count beyond depth");

  // An accepted word leaves the sequencer busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("word accepted while the previous one is still in work");

  // Giving a result starts a fresh expression.
  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (vcnt_q == '0) && (ocnt_q == '0) && !in_num_q && !err_q && outv_q)
    else $error("state not cleared after a result");

endmodule

// ===== tb/tb_infix_add_sub_paren_evaluator.sv =====
// ----------------------------------------------------------------------------
// tb_infix_add_sub_paren_evaluator: regression for the expression evaluator
// Streams expression characters into the evaluator and keeps its own copy of
// the value and operator stacks to work out each expected total. Every total
// that comes out is checked field by field against the oldest expected one.
// The run covers directed corner cases, random well-formed and broken
// expressions, stack overflow and underflow, idle and stall patterns on both
// channels, and a long receiver hold-off that backs the input up.
// ----------------------------------------------------------------------------
module tb_infix_add_sub_paren_evaluator;

  localparam int unsigned DEPTH          = ipe_pkg::STACK_DEPTH_DEF;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          SETTLE_CYCLES  = 200;
  localparam int          HOLD_CYCLES    = 500;

  // One expected total: the value of an expression and its error flag.
  typedef struct packed {
    logic signed [ipe_pkg::DATA_W-1:0] value;
    logic                              err;
  } total_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ipe_in_if  in_if ();
  ipe_out_if out_if ();

  infix_add_sub_paren_evaluator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Clock with a period of 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  total_t      expected_totals[$];
  logic [7:0]  expr_buf[$];
  int          fail_count = 0;
  int          live_items = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_request = 0;

  // Evaluator state as the design should hold it.
  logic [ipe_pkg::DATA_W-1:0] val_stk [DEPTH];
  ipe_pkg::op_code_e          op_stk [DEPTH];
  int unsigned                val_cnt = 0;
  int unsigned                op_cnt = 0;
  logic [ipe_pkg::DATA_W-1:0] num_acc = '0;
  bit                         num_open = 1'b0;
  bit                         stk_err = 1'b0;

  function automatic bit is_expr_char(input logic [7:0] c);
    if (c >= ipe_pkg::CHAR_ZERO && c <= ipe_pkg::CHAR_NINE) begin
      return 1'b1;
    end
    case (c)
      ipe_pkg::CHAR_SPACE, ipe_pkg::CHAR_OPEN, ipe_pkg::CHAR_CLOSE,
      ipe_pkg::CHAR_PLUS, ipe_pkg::CHAR_MINUS: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void eval_clear();
    val_cnt  = 0;
    op_cnt   = 0;
    num_acc  = '0;
    num_open = 1'b0;
    stk_err  = 1'b0;
  endfunction

  // A push onto a full stack is dropped and flags an error.
  function automatic void val_push(input logic [ipe_pkg::DATA_W-1:0] v);
    if (val_cnt >= DEPTH) begin
      stk_err = 1'b1;
    end else begin
      val_stk[val_cnt] = v;
      val_cnt++;
    end
  endfunction

  // An empty value stack yields zero and flags an error.
  function automatic logic [ipe_pkg::DATA_W-1:0] val_pop();
    if (val_cnt == 0) begin
      stk_err = 1'b1;
      return '0;
    end
    val_cnt--;
    return val_stk[val_cnt];
  endfunction

  function automatic void op_push(input ipe_pkg::op_code_e op);
    if (op_cnt >= DEPTH) begin
      stk_err = 1'b1;
    end else begin
      op_stk[op_cnt] = op;
      op_cnt++;
    end
  endfunction

  function automatic logic [ipe_pkg::DATA_W-1:0] combine(
    input ipe_pkg::op_code_e          op,
    input logic [ipe_pkg::DATA_W-1:0] lhs,
    input logic [ipe_pkg::DATA_W-1:0] rhs
  );
    return (op == ipe_pkg::OP_PLUS) ? lhs + rhs : lhs - rhs;
  endfunction

  // A finished number is pushed, or folded into the top by a pending operator.
  function automatic void end_number();
    logic [ipe_pkg::DATA_W-1:0] n;
    ipe_pkg::op_code_e          top;
    if (!num_open) begin
      return;
    end
    n        = num_acc;
    num_acc  = '0;
    num_open = 1'b0;
    if (op_cnt == 0 || op_stk[op_cnt-1] == ipe_pkg::OP_OPEN) begin
      val_push(n);
      return;
    end
    top = op_stk[op_cnt-1];
    op_cnt--;
    val_push(combine(top, val_pop(), n));
  endfunction

  // Drop the opening mark, then reduce down to the next opening mark.
  function automatic void close_group();
    ipe_pkg::op_code_e          op;
    logic [ipe_pkg::DATA_W-1:0] rhs;
    logic [ipe_pkg::DATA_W-1:0] lhs;
    if (op_cnt != 0 && op_stk[op_cnt-1] == ipe_pkg::OP_OPEN) begin
      op_cnt--;
    end
    while (op_cnt != 0 && op_stk[op_cnt-1] != ipe_pkg::OP_OPEN) begin
      op  = op_stk[op_cnt-1];
      rhs = val_pop();
      lhs = val_pop();
      op_cnt--;
      val_push(combine(op, lhs, rhs));
    end
  endfunction

  // Advance the evaluator by one character; the last one yields a total.
  function automatic void eval_char(input logic [7:0] c, input logic last);
    total_t t;
    if (c >= ipe_pkg::CHAR_ZERO && c <= ipe_pkg::CHAR_NINE) begin
      num_acc  = num_acc * 32'd10 + 32'(c - ipe_pkg::CHAR_ZERO);
      num_open = 1'b1;
    end else if (is_expr_char(c)) begin
      end_number();
      case (c)
        ipe_pkg::CHAR_OPEN:  op_push(ipe_pkg::OP_OPEN);
        ipe_pkg::CHAR_PLUS:  op_push(ipe_pkg::OP_PLUS);
        ipe_pkg::CHAR_MINUS: op_push(ipe_pkg::OP_MINUS);
        ipe_pkg::CHAR_CLOSE: close_group();
        default: ;
      endcase
    end
    if (last) begin
      end_number();
      if (val_cnt == 0) begin
        stk_err = 1'b1;
        t.value = '0;
      end else begin
        t.value = val_stk[val_cnt-1];
      end
      t.err = stk_err;
      expected_totals.push_back(t);
      eval_clear();
    end
  endfunction

  // Expression builders; they fill expr_buf.
  function automatic void put_char(input logic [7:0] c);
    expr_buf.push_back(c);
  endfunction

  function automatic void put_op();
    put_char($urandom_range(1) ? ipe_pkg::CHAR_PLUS : ipe_pkg::CHAR_MINUS);
  endfunction

  function automatic void maybe_space();
    if ($urandom_range(3) == 0) begin
      put_char(ipe_pkg::CHAR_SPACE);
    end
  endfunction

  // Mostly short numbers; now and then long enough to wrap the accumulator.
  function automatic void add_number();
    int len;
    int k;
    len = ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(4, 11);
    for (k = 0; k < len; k++) begin
      put_char(ipe_pkg::CHAR_ZERO + 8'($urandom_range(9)));
    end
  endfunction

  function automatic void load_text(input string s);
    int k;
    expr_buf.delete();
    for (k = 0; k < s.len(); k++) begin
      put_char(s[k]);
    end
  endfunction

  // Balanced expression with random nesting, spacing and now and then noise.
  function automatic void build_sane_expr();
    int depth;
    int terms;
    int t;
    int k;
    expr_buf.delete();
    depth = 0;
    terms = $urandom_range(1, 6);
    for (t = 0; t < terms; t++) begin
      while (depth < 8 && $urandom_range(99) < 25) begin
        put_char(ipe_pkg::CHAR_OPEN);
        maybe_space();
        depth++;
      end
      add_number();
      while (depth > 0 && $urandom_range(99) < 35) begin
        put_char(ipe_pkg::CHAR_CLOSE);
        depth--;
      end
      if (t != terms - 1) begin
        maybe_space();
        put_op();
        maybe_space();
      end
    end
    while (depth > 0) begin
      put_char(ipe_pkg::CHAR_CLOSE);
      depth--;
    end
    if ($urandom_range(99) < 15) begin
      for (k = $urandom_range(1, 3); k > 0; k--) begin
        expr_buf.insert($urandom_range(expr_buf.size()), 8'($urandom_range(255)));
      end
    end
  endfunction

  // Random characters, mostly from the expression set.
  function automatic void build_junk();
    int len;
    int k;
    logic [7:0] pick;
    expr_buf.delete();
    len = $urandom_range(1, 12);
    for (k = 0; k < len; k++) begin
      case ($urandom_range(7))
        0, 1: pick = ipe_pkg::CHAR_ZERO + 8'($urandom_range(9));
        2:    pick = ipe_pkg::CHAR_SPACE;
        3:    pick = ipe_pkg::CHAR_OPEN;
        4:    pick = ipe_pkg::CHAR_CLOSE;
        5:    pick = ipe_pkg::CHAR_PLUS;
        6:    pick = ipe_pkg::CHAR_MINUS;
        default: pick = 8'($urandom_range(255));
      endcase
      put_char(pick);
    end
  endfunction

  // Offer one word and wait for it to be taken. Called right after a falling
  // edge and returns right after one.
  task automatic send_word(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    in_if.is_last   <= last;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) begin
      @(posedge clk_i);
    end
    eval_char(c, last);
    if (is_expr_char(c)) begin
      live_items++;
    end
    @(negedge clk_i);
  endtask

  task automatic send_expr();
    int k;
    for (k = 0; k < expr_buf.size(); k++) begin
      send_word(expr_buf[k], k == expr_buf.size() - 1);
    end
  endtask

  // Stop offering and wait until every expected total has come out.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (expected_totals.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Corner cases: every operator, ignored codes at both ends of the byte
  // range, a last flag on an ignored code, operand underflow, a close with no
  // operators, an empty expression and accumulator wrap.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_text("9-(8+7)");
    send_expr();
    load_text("1");
    put_char(8'h00);
    put_char(ipe_pkg::CHAR_ZERO);
    put_char(8'hFF);
    send_expr();
    load_text("-5");
    send_expr();
    load_text(")3");
    send_expr();
    load_text(" ");
    send_expr();
    load_text("4294967299");
    send_expr();
    wait_for_results();
  endtask

  // Random expressions under one idle and stall setting.
  task automatic test_random_mix(input int idle_pct, input int stall_pct, input int n_items);
    int start;
    int r;
    int keep;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = live_items;
    while (live_items - start < n_items) begin
      r = $urandom_range(99);
      if (r < 80) begin
        build_sane_expr();
      end else if (r < 90) begin
        // Cut a good expression short so it ends mid-number or mid-group.
        build_sane_expr();
        keep = $urandom_range(1, expr_buf.size());
        while (expr_buf.size() > keep) begin
          void'(expr_buf.pop_back());
        end
      end else begin
        build_junk();
      end
      send_expr();
    end
    wait_for_results();
  endtask

  // Fill both stacks past their depth and force long reductions.
  task automatic test_stack_limits();
    int round;
    int n;
    int k;
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    for (round = 0; round < 3; round++) begin
      // Deep nesting of opening marks.
      expr_buf.delete();
      n = $urandom_range(DEPTH - 2, DEPTH + 4);
      for (k = 0; k < n; k++) begin
        put_char(ipe_pkg::CHAR_OPEN);
        if ($urandom_range(3) == 0) begin
          add_number();
          put_op();
        end
      end
      add_number();
      for (k = $urandom_range(n); k > 0; k--) begin
        put_char(ipe_pkg::CHAR_CLOSE);
      end
      send_expr();
      // More numbers than the value stack holds.
      expr_buf.delete();
      n = $urandom_range(DEPTH - 2, DEPTH + 4);
      for (k = 0; k < n; k++) begin
        add_number();
        put_char(ipe_pkg::CHAR_SPACE);
      end
      send_expr();
      // A run of operators reduced by a single closing paren.
      expr_buf.delete();
      add_number();
      n = $urandom_range(DEPTH - 4, DEPTH + 2);
      for (k = 0; k < n; k++) begin
        put_op();
      end
      put_char(ipe_pkg::CHAR_OPEN);
      add_number();
      put_char(ipe_pkg::CHAR_CLOSE);
      send_expr();
    end
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while short expressions keep
  // coming, so the evaluator backs up and stalls its input.
  task automatic test_backpressure();
    int k;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    for (k = 0; k < 10; k++) begin
      expr_buf.delete();
      add_number();
      put_op();
      add_number();
      send_expr();
    end
    wait_for_results();
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold_len;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_len     = hold_request;
        hold_request = 0;
        out_if.ready <= 1'b0;
        repeat (hold_len) @(negedge clk_i);
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every accepted total against the oldest expected one.
  always @(posedge clk_i) begin
    total_t exp_t;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_totals.size() == 0) begin
        $error("total with no expression pending: result_value %0d, error_flag %0b",
               out_if.result_value, out_if.error_flag);
        fail_count++;
      end else begin
        exp_t = expected_totals.pop_front();
        if (out_if.result_value !== exp_t.value) begin
          $error("result_value: expected %0d, actual %0d",
                 $signed(exp_t.value), out_if.result_value);
          fail_count++;
        end
        if (out_if.error_flag !== exp_t.err) begin
          $error("error_flag: expected %0b, actual %0b", exp_t.err, out_if.error_flag);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("infix_add_sub_paren_evaluator regression: fail");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.char_code = '0;
    in_if.is_last   = 1'b0;
    eval_clear();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_mix(0, 0, 350);
    test_random_mix(68, 0, 350);
    test_backpressure();
    test_random_mix(0, 68, 350);
    test_random_mix(27, 27, 350);
    test_stack_limits();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (expected_totals.size() != 0) begin
      $error("%0d expected totals never came out", expected_totals.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("infix_add_sub_paren_evaluator regression: pass");
    end else begin
      $display("infix_add_sub_paren_evaluator regression: fail");
    end
    $finish;
  end

endmodule
